FILE: sv/gcpc_pkg.sv
// ----------------------------------------------------------------------------
// gcpc_pkg
// Shared types and constants for the graph closure and property check block.
// ----------------------------------------------------------------------------
package gcpc_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int VERTEX_W     = 7;
    localparam int ROW_VERTEX_W = 6;
    localparam int REACH_W      = 64;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 4;
    localparam int OUT_PAD_W  = OUT_DATA_W - ROW_VERTEX_W - REACH_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VCOUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE     = 2'd2;

    localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_RD,
        ST_E_WR1,
        ST_E_WR2,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_PV_RD,
        ST_PV_LAT,
        ST_CL_RD,
        ST_CL_WR,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    typedef struct packed {
        logic edge_take;
        logic edge_rd;
        logic wr_from;
        logic wr_to;
        logic init_rd;
        logic init_wr;
        logic pv_rd;
        logic pv_lat;
        logic cl_rd;
        logic cl_wr;
        logic out_rd;
        logic out_ld;
        logic clr_row;
        logic inc_row;
        logic clr_piv;
        logic inc_piv;
        logic init_flags;
        logic end_run;
    } cmd_t;

    typedef struct packed {
        logic edge_bad;
        logic edge_last;
        logic directed;
        logic row_last;
        logic piv_last;
        logic out_free;
    } stat_t;

endpackage

FILE: sv/graph_closure_and_property_check.sv
// ----------------------------------------------------------------------------
// graph_closure_and_property_check
// Edge loader with transitive closure and graph property flags.
// ----------------------------------------------------------------------------
// Edges arrive on the s_axis stream, one request per edge, tlast on the final
// edge of a graph. The endpoints are rebased and set in a row memory, mirrored
// when the graph is undirected. Each edge reads its two rows together, then
// the one write port takes both rows in turn (undirected), one (directed) or
// none (dropped). After the final edge a mask pass reads and writes each row;
// the closure then reads and latches each pivot row and reads and writes every
// row for it. The n rows leave on m_axis, each read from memory first, tlast on
// the final row, flags in tuser. Input is not accepted from the final edge
// until the final row sits in the output register.
// The cfg channel is always ready and is meant for use while the block is idle.
// Reset returns the registers to their defaults and clears the row valid bits,
// so the graph reads empty at once. A stalled receiver holds the output
// register and the output sequence simply waits.
// ----------------------------------------------------------------------------
module graph_closure_and_property_check #(
    parameter int MAX_VERTICES = gcpc_pkg::MAX_VERTICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // from_vertex[6:0], to_vertex[13:7], zero pad
    input  logic [gcpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // row_vertex[5:0], reach_row[69:6], zero pad
    output logic [gcpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // is_complete[0], has_self_loop[1], is_multigraph[2], bad_edge_seen[3]
    output logic [gcpc_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gcpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    gcpc_pkg::cmd_t  cmd;
    gcpc_pkg::stat_t stat;

    logic [gcpc_pkg::ROW_VERTEX_W-1:0] row_vertex;
    logic [gcpc_pkg::REACH_W-1:0]      reach_row;
    logic is_complete;
    logic has_self_loop;
    logic is_multigraph;
    logic bad_edge_seen;

    gcpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gcpc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .from_vertex   (s_axis_tdata[gcpc_pkg::VERTEX_W-1:0]),
        .to_vertex     (s_axis_tdata[2*gcpc_pkg::VERTEX_W-1:gcpc_pkg::VERTEX_W]),
        .last_edge     (s_axis_tlast),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .row_vertex    (row_vertex),
        .reach_row     (reach_row),
        .is_complete   (is_complete),
        .has_self_loop (has_self_loop),
        .is_multigraph (is_multigraph),
        .bad_edge_seen (bad_edge_seen),
        .last_row      (m_axis_tlast)
    );

    assign m_axis_tdata = {{gcpc_pkg::OUT_PAD_W{1'b0}}, reach_row, row_vertex};
    assign m_axis_tuser = {bad_edge_seen, is_multigraph, has_self_loop, is_complete};

    // no edge is taken while rows of a run are still to come
    a_no_edge_mid_output: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("edge accepted while a run is still being emitted");

    // each edge goes through a read-modify-write before the next one
    a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held high right after an edge request");

    // the next row needs a memory read, so the output goes empty between rows
    a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !m_axis_tvalid)
        else $error("row presented without a memory read in between");

endmodule

FILE: sv/gcpc_ram.sv
// ----------------------------------------------------------------------------
// gcpc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gcpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_a_en,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    input  logic                     rd_b_en,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_data <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

FILE: sv/gcpc_ctrl.sv
// ----------------------------------------------------------------------------
// gcpc_ctrl
// Controller: edge load, mask pass, closure sweeps and row output sequencing.
// ----------------------------------------------------------------------------
module gcpc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gcpc_pkg::stat_t stat,
    output gcpc_pkg::cmd_t  cmd
);

    gcpc_pkg::state_t state_reg;
    gcpc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gcpc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gcpc_pkg::ST_E_RD;
                end
            end
            gcpc_pkg::ST_E_RD:
            begin
                state_next = gcpc_pkg::ST_E_WR1;
            end
            gcpc_pkg::ST_E_WR1:
            begin
                if (!stat.edge_bad && !stat.directed)
                begin
                    state_next = gcpc_pkg::ST_E_WR2;
                end
                else if (stat.edge_last)
                begin
                    state_next = gcpc_pkg::ST_INIT_RD;
                end
                else
                begin
                    state_next = gcpc_pkg::ST_IDLE;
                end
            end
            gcpc_pkg::ST_E_WR2:
            begin
                if (stat.edge_last)
                begin
                    state_next = gcpc_pkg::ST_INIT_RD;
                end
                else
                begin
                    state_next = gcpc_pkg::ST_IDLE;
                end
            end
            gcpc_pkg::ST_INIT_RD:
            begin
                state_next = gcpc_pkg::ST_INIT_WR;
            end
            gcpc_pkg::ST_INIT_WR:
            begin
                state_next = stat.row_last ? gcpc_pkg::ST_PV_RD : gcpc_pkg::ST_INIT_RD;
            end
            gcpc_pkg::ST_PV_RD:
            begin
                state_next = gcpc_pkg::ST_PV_LAT;
            end
            gcpc_pkg::ST_PV_LAT:
            begin
                state_next = gcpc_pkg::ST_CL_RD;
            end
            gcpc_pkg::ST_CL_RD:
            begin
                state_next = gcpc_pkg::ST_CL_WR;
            end
            gcpc_pkg::ST_CL_WR:
            begin
                if (!stat.row_last)
                begin
                    state_next = gcpc_pkg::ST_CL_RD;
                end
                else if (stat.piv_last)
                begin
                    state_next = gcpc_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = gcpc_pkg::ST_PV_RD;
                end
            end
            gcpc_pkg::ST_OUT_RD:
            begin
                if (stat.out_free)
                begin
                    state_next = gcpc_pkg::ST_OUT_LD;
                end
            end
            gcpc_pkg::ST_OUT_LD:
            begin
                state_next = stat.row_last ? gcpc_pkg::ST_IDLE : gcpc_pkg::ST_OUT_RD;
            end
            default:
            begin
                state_next = gcpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            gcpc_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.edge_take = in_valid;
            end
            gcpc_pkg::ST_E_RD:
            begin
                cmd.edge_rd = 1'b1;
            end
            gcpc_pkg::ST_E_WR1:
            begin
                cmd.wr_from = !stat.edge_bad;
                if ((stat.edge_bad || stat.directed) && stat.edge_last)
                begin
                    cmd.clr_row    = 1'b1;
                    cmd.init_flags = 1'b1;
                end
            end
            gcpc_pkg::ST_E_WR2:
            begin
                cmd.wr_to = 1'b1;
                if (stat.edge_last)
                begin
                    cmd.clr_row    = 1'b1;
                    cmd.init_flags = 1'b1;
                end
            end
            gcpc_pkg::ST_INIT_RD:
            begin
                cmd.init_rd = 1'b1;
            end
            gcpc_pkg::ST_INIT_WR:
            begin
                cmd.init_wr = 1'b1;
                if (stat.row_last)
                begin
                    cmd.clr_piv = 1'b1;
                end
                else
                begin
                    cmd.inc_row = 1'b1;
                end
            end
            gcpc_pkg::ST_PV_RD:
            begin
                cmd.pv_rd = 1'b1;
            end
            gcpc_pkg::ST_PV_LAT:
            begin
                cmd.pv_lat  = 1'b1;
                cmd.clr_row = 1'b1;
            end
            gcpc_pkg::ST_CL_RD:
            begin
                cmd.cl_rd = 1'b1;
            end
            gcpc_pkg::ST_CL_WR:
            begin
                cmd.cl_wr = 1'b1;
                if (!stat.row_last)
                begin
                    cmd.inc_row = 1'b1;
                end
                else if (stat.piv_last)
                begin
                    cmd.clr_row = 1'b1;
                end
                else
                begin
                    cmd.inc_piv = 1'b1;
                end
            end
            gcpc_pkg::ST_OUT_RD:
            begin
                cmd.out_rd = stat.out_free;
            end
            gcpc_pkg::ST_OUT_LD:
            begin
                cmd.out_ld = 1'b1;
                if (stat.row_last)
                begin
                    cmd.end_run = 1'b1;
                end
                else
                begin
                    cmd.inc_row = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/gcpc_datapath.sv
// ----------------------------------------------------------------------------
// gcpc_datapath
// Registers, row memory with valid bits, edge checks, closure and output row.
// ----------------------------------------------------------------------------
module gcpc_datapath #(
    parameter int MAX_VERTICES = gcpc_pkg::MAX_VERTICES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gcpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gcpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [gcpc_pkg::VERTEX_W-1:0]      from_vertex,
    input  logic [gcpc_pkg::VERTEX_W-1:0]      to_vertex,
    input  logic                               last_edge,
    input  gcpc_pkg::cmd_t                     cmd,
    output gcpc_pkg::stat_t                    stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gcpc_pkg::ROW_VERTEX_W-1:0]  row_vertex,
    output logic [gcpc_pkg::REACH_W-1:0]       reach_row,
    output logic                               is_complete,
    output logic                               has_self_loop,
    output logic                               is_multigraph,
    output logic                               bad_edge_seen,
    output logic                               last_row
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int VW = gcpc_pkg::VERTEX_W;

    logic                 directed_reg;
    logic [VW-1:0]        vcount_reg;
    logic                 base_reg;

    logic [AW-1:0]        from_idx_reg;
    logic [AW-1:0]        to_idx_reg;
    logic                 edge_bad_reg;
    logic                 edge_last_reg;

    logic [CW-1:0]        row_reg;
    logic [CW-1:0]        piv_reg;
    logic [MAX_VERTICES-1:0] pivot_row_reg;
    logic                 complete_reg;
    logic                 self_loop_reg;
    logic                 multi_reg;
    logic                 bad_reg;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic                 valid_a_reg;
    logic                 valid_b_reg;
    logic                 out_valid_reg;

    logic [gcpc_pkg::ROW_VERTEX_W-1:0] out_vertex_reg;
    logic [MAX_VERTICES-1:0]           out_row_reg;
    logic                 out_complete_reg;
    logic                 out_self_reg;
    logic                 out_multi_reg;
    logic                 out_bad_reg;
    logic                 out_last_reg;

    logic [VW-1:0]        n_clamp;
    logic [CW-1:0]        n_eff;
    logic [MAX_VERTICES-1:0] mask;
    logic [VW-1:0]        from_sub;
    logic [VW-1:0]        to_sub;
    logic                 in_bad;

    logic [AW-1:0]        row_idx;
    logic [AW-1:0]        piv_idx;
    logic                 rd_a_en;
    logic [AW-1:0]        rd_a_addr;
    logic [MAX_VERTICES-1:0] rd_a_data;
    logic [MAX_VERTICES-1:0] rd_b_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MAX_VERTICES-1:0] wr_data;
    logic [MAX_VERTICES-1:0] row_a;
    logic [MAX_VERTICES-1:0] row_b;
    logic [MAX_VERTICES-1:0] row_m;
    logic [MAX_VERTICES-1:0] bit_from;
    logic [MAX_VERTICES-1:0] bit_to;
    logic [MAX_VERTICES-1:0] bit_row;
    logic [MAX_VERTICES-1:0] bit_piv;
    logic                 cfg_take;

    // vertex count clamp and mask of vertices in use
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_clamp = VW'(1);
        end
        else if (vcount_reg > VW'(MAX_VERTICES))
        begin
            n_clamp = VW'(MAX_VERTICES);
        end
        else
        begin
            n_clamp = vcount_reg;
        end
    end

    assign n_eff = CW'(n_clamp);

    always_comb
    begin
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            mask[j] = (n_eff > CW'(j));
        end
    end

    // endpoint checks on the incoming edge
    assign from_sub = from_vertex - VW'(base_reg);
    assign to_sub   = to_vertex - VW'(base_reg);
    assign in_bad   = (from_vertex < VW'(base_reg)) || (to_vertex < VW'(base_reg))
                   || (from_sub >= n_clamp) || (to_sub >= n_clamp);

    assign row_idx = row_reg[AW-1:0];
    assign piv_idx = piv_reg[AW-1:0];

    assign bit_from = MAX_VERTICES'(1) << from_idx_reg;
    assign bit_to   = MAX_VERTICES'(1) << to_idx_reg;
    assign bit_row  = MAX_VERTICES'(1) << row_idx;
    assign bit_piv  = MAX_VERTICES'(1) << piv_idx;

    // rows never written since the last run read as zero
    assign row_a = valid_a_reg ? rd_a_data : '0;
    assign row_b = valid_b_reg ? rd_b_data : '0;
    assign row_m = row_a & mask;

    assign rd_a_en = cmd.edge_rd | cmd.init_rd | cmd.pv_rd | cmd.cl_rd | cmd.out_rd;

    always_comb
    begin
        if (cmd.edge_rd)
        begin
            rd_a_addr = from_idx_reg;
        end
        else if (cmd.pv_rd)
        begin
            rd_a_addr = piv_idx;
        end
        else
        begin
            rd_a_addr = row_idx;
        end
    end

    assign wr_en = cmd.wr_from | cmd.wr_to | cmd.init_wr | cmd.cl_wr;

    always_comb
    begin
        if (cmd.wr_from)
        begin
            wr_addr = from_idx_reg;
            wr_data = row_a | bit_to;
        end
        else if (cmd.wr_to)
        begin
            wr_addr = to_idx_reg;
            wr_data = row_b | bit_from;
        end
        else if (cmd.init_wr)
        begin
            wr_addr = row_idx;
            wr_data = row_m;
        end
        else
        begin
            wr_addr = row_idx;
            wr_data = ((row_a & bit_piv) != '0) ? (row_a | pivot_row_reg) : row_a;
        end
    end

    gcpc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (cmd.edge_rd),
        .rd_b_addr (to_idx_reg),
        .rd_b_data (rd_b_data)
    );

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg <= 1'b0;
            vcount_reg   <= gcpc_pkg::VCOUNT_RESET;
            base_reg     <= 1'b1;
        end
        else if (cfg_take)
        begin
            case (cfg_index)
                gcpc_pkg::CFG_DIRECTED: directed_reg <= cfg_data[0];
                gcpc_pkg::CFG_VCOUNT:   vcount_reg   <= cfg_data;
                gcpc_pkg::CFG_BASE:     base_reg     <= cfg_data[0];
                default:                directed_reg <= directed_reg;
            endcase
        end
    end

    // control and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_bad_reg  <= 1'b0;
            edge_last_reg <= 1'b0;
            row_reg       <= '0;
            piv_reg       <= '0;
            complete_reg  <= 1'b1;
            self_loop_reg <= 1'b0;
            multi_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            valid_reg     <= '0;
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.edge_take)
            begin
                edge_bad_reg  <= in_bad;
                edge_last_reg <= last_edge;
                if (in_bad)
                begin
                    bad_reg <= 1'b1;
                end
            end
            if (rd_a_en)
            begin
                valid_a_reg <= valid_reg[rd_a_addr];
            end
            if (cmd.edge_rd)
            begin
                valid_b_reg <= valid_reg[to_idx_reg];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.wr_from && (from_idx_reg != to_idx_reg)
                && (((row_a & bit_to) != '0) || ((row_b & bit_from) != '0)))
            begin
                multi_reg <= 1'b1;
            end
            if (cmd.init_flags)
            begin
                complete_reg  <= 1'b1;
                self_loop_reg <= 1'b0;
            end
            if (cmd.init_wr)
            begin
                if ((row_m & bit_row) != '0)
                begin
                    self_loop_reg <= 1'b1;
                end
                if ((row_m | bit_row) != mask)
                begin
                    complete_reg <= 1'b0;
                end
            end
            if (cmd.clr_row)
            begin
                row_reg <= '0;
            end
            else if (cmd.inc_row)
            begin
                row_reg <= row_reg + CW'(1);
            end
            if (cmd.clr_piv)
            begin
                piv_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.inc_piv)
            begin
                piv_reg <= piv_reg + CW'(1);
                row_reg <= '0;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.end_run)
            begin
                valid_reg <= '0;
                multi_reg <= 1'b0;
                bad_reg   <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.edge_take)
        begin
            from_idx_reg <= from_sub[AW-1:0];
            to_idx_reg   <= to_sub[AW-1:0];
        end
        if (cmd.pv_lat)
        begin
            pivot_row_reg <= row_a;
        end
        if (cmd.out_ld)
        begin
            out_vertex_reg   <= gcpc_pkg::ROW_VERTEX_W'(row_reg);
            out_row_reg      <= row_m;
            out_complete_reg <= complete_reg;
            out_self_reg     <= self_loop_reg;
            out_multi_reg    <= multi_reg;
            out_bad_reg      <= bad_reg;
            out_last_reg     <= stat.row_last;
        end
    end

    assign stat.edge_bad  = edge_bad_reg;
    assign stat.edge_last = edge_last_reg;
    assign stat.directed  = directed_reg;
    assign stat.row_last  = ((row_reg + CW'(1)) == n_eff);
    assign stat.piv_last  = ((piv_reg + CW'(1)) == n_eff);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign row_vertex    = out_vertex_reg;
    assign reach_row     = gcpc_pkg::REACH_W'(out_row_reg);
    assign is_complete   = out_complete_reg;
    assign has_self_loop = out_self_reg;
    assign is_multigraph = out_multi_reg;
    assign bad_edge_seen = out_bad_reg;
    assign last_row      = out_last_reg;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the graph closure and property check block.
// ----------------------------------------------------------------------------
// Edge requests are queued by the stimulus process and sent by a clocked
// driver. Each accepted edge updates a local adjacency copy. A final edge
// computes the expected reachability rows and flags. A clocked monitor checks
// every output row against the oldest expected row. The directed part covers
// self-loops, repeated pairs, dropped edges, a dropped final edge, a clamped
// vertex count and a register change in the middle of a graph. The random part
// then sweeps the register settings and the idle and stall rates, with one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [gcpc_pkg::VERTEX_W-1:0] src;
        logic [gcpc_pkg::VERTEX_W-1:0] dst;
        logic                          last;
    } arc_t;

    typedef struct {
        logic [gcpc_pkg::ROW_VERTEX_W-1:0] vertex;
        logic [gcpc_pkg::REACH_W-1:0]      reach;
        logic                              complete;
        logic                              self_loop;
        logic                              multi;
        logic                              bad;
        logic                              last;
    } row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [gcpc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [gcpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [gcpc_pkg::OUT_USER_W-1:0]  m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [gcpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gcpc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    graph_closure_and_property_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // local copy of the block state
    logic                          cfg_dir  = 1'b0;
    logic [gcpc_pkg::VERTEX_W-1:0] cfg_vc   = gcpc_pkg::VCOUNT_RESET;
    logic                          cfg_base = 1'b1;
    logic [gcpc_pkg::REACH_W-1:0]  adj_rows [64];
    logic                          multi_flag = 1'b0;
    logic                          bad_flag   = 1'b0;

    arc_t arc_q [$];
    row_t reach_q [$];
    arc_t cur_arc;
    bit   arc_busy = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int errors      = 0;
    int total_items = 0;
    int graphs_done = 0;
    int rows_seen   = 0;
    int phases_run  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int active_n();
        int n;
        n = cfg_vc;
        if (n < 1) n = 1;
        if (n > gcpc_pkg::MAX_VERTICES_DEF) n = gcpc_pkg::MAX_VERTICES_DEF;
        return n;
    endfunction

    task automatic predict_rows(input arc_t a);
        int                           n;
        logic [gcpc_pkg::REACH_W-1:0] mask;
        logic [gcpc_pkg::REACH_W-1:0] cl [64];
        logic                         complete;
        logic                         self_loop;
        int                           f;
        int                           t;
        row_t                         r;
        n = active_n();
        mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        complete = 1'b1;
        self_loop = 1'b0;
        if (a.src < cfg_base || a.dst < cfg_base)
            bad_flag = 1'b1;
        else
        begin
            f = a.src - cfg_base;
            t = a.dst - cfg_base;
            if (f >= n || t >= n)
                bad_flag = 1'b1;
            else
            begin
                if (f != t && (adj_rows[f][t] || adj_rows[t][f]))
                    multi_flag = 1'b1;
                adj_rows[f][t] = 1'b1;
                if (!cfg_dir)
                    adj_rows[t][f] = 1'b1;
            end
        end
        if (!a.last)
            return;
        for (int i = 0; i < n; i++)
        begin
            cl[i] = adj_rows[i] & mask;
            if (cl[i][i])
                self_loop = 1'b1;
            if ((cl[i] | (64'd1 << i)) != mask)
                complete = 1'b0;
        end
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                if (cl[i][k])
                    cl[i] = cl[i] | cl[k];
        for (int i = 0; i < n; i++)
        begin
            r.vertex    = i[gcpc_pkg::ROW_VERTEX_W-1:0];
            r.reach     = cl[i] & mask;
            r.complete  = complete;
            r.self_loop = self_loop;
            r.multi     = multi_flag;
            r.bad       = bad_flag;
            r.last      = (i + 1 == n);
            reach_q.push_back(r);
        end
        for (int i = 0; i < 64; i++)
            adj_rows[i] = '0;
        multi_flag = 1'b0;
        bad_flag = 1'b0;
        graphs_done++;
    endtask

    // edge request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                predict_rows(cur_arc);
                arc_busy = 1'b0;
            end
            if (arc_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_arc = arc_q.pop_front();
                arc_busy = 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, cur_arc.dst, cur_arc.src};
                s_axis_tlast  <= cur_arc.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver ready, with one long hold-off once the output starts
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done && m_axis_tvalid)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t row %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // row monitor
    always @(posedge clk)
    begin
        row_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            rows_seen++;
            if (reach_q.size() == 0)
            begin
                $display("%0t unexpected row: expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                e = reach_q.pop_front();
                check_field("vertex", 64'(e.vertex), 64'(m_axis_tdata[5:0]));
                check_field("reach", e.reach, m_axis_tdata[69:6]);
                check_field("complete", 64'(e.complete), 64'(m_axis_tuser[0]));
                check_field("self_loop", 64'(e.self_loop), 64'(m_axis_tuser[1]));
                check_field("multigraph", 64'(e.multi), 64'(m_axis_tuser[2]));
                check_field("bad_edge", 64'(e.bad), 64'(m_axis_tuser[3]));
                check_field("last", 64'(e.last), 64'(m_axis_tlast));
            end
        end
    end

    task automatic write_reg(input logic [gcpc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [gcpc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            gcpc_pkg::CFG_DIRECTED: cfg_dir  = val[0];
            gcpc_pkg::CFG_VCOUNT:   cfg_vc   = val;
            gcpc_pkg::CFG_BASE:     cfg_base = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic push_arc(input int src, input int dst, input bit last);
        arc_t a;
        a.src  = src[gcpc_pkg::VERTEX_W-1:0];
        a.dst  = dst[gcpc_pkg::VERTEX_W-1:0];
        a.last = last;
        arc_q.push_back(a);
        total_items++;
    endtask

    task automatic settle();
        while (!(arc_q.size() == 0 && !arc_busy && reach_q.size() == 0))
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic queue_graph(input int n, input int base, input bit dir);
        int cnt;
        int a;
        int b;
        bit last;
        if ($urandom_range(0, 5) == 0 && n <= 5)
        begin
            // every pair present, so the graph comes out complete
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    last = (n == 1) || (dir ? (i == n - 1 && j == n - 2)
                                            : (i == n - 2 && j == n - 1));
                    if ((dir && i != j) || (!dir && i < j) || n == 1)
                        push_arc(base + i, base + j, last);
                end
        end
        else
        begin
            cnt = $urandom_range(0, (n <= 12) ? 2 * n : 20);
            for (int i = 0; i <= cnt; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    a = $urandom_range(0, 127);
                    b = $urandom_range(0, 127);
                end
                else
                begin
                    a = base + $urandom_range(0, n - 1);
                    b = base + $urandom_range(0, n - 1);
                end
                push_arc(a, b, i == cnt);
            end
        end
    endtask

    initial
    begin
        int ph;
        int vc;
        int n;
        int base;
        bit dir;
        for (int i = 0; i < 64; i++)
            adj_rows[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: undirected, 64 vertices, base 1
        push_arc(1, 2, 0);
        push_arc(2, 3, 0);
        push_arc(64, 64, 0);
        push_arc(0, 5, 0);
        push_arc(65, 3, 0);
        push_arc(3, 2, 0);
        push_arc(1, 64, 1);
        settle();

        // directed complete graph on 3 vertices, base 0
        write_reg(gcpc_pkg::CFG_DIRECTED, 7'd1);
        write_reg(gcpc_pkg::CFG_VCOUNT, 7'd3);
        write_reg(gcpc_pkg::CFG_BASE, 7'd0);
        push_arc(0, 1, 0);
        push_arc(1, 0, 0);
        push_arc(0, 2, 0);
        push_arc(2, 0, 0);
        push_arc(1, 2, 0);
        push_arc(2, 1, 0);
        // dropped final edge still ends the graph
        push_arc(0, 1, 0);
        push_arc(5, 0, 1);
        settle();

        // vertex count zero acts as one
        write_reg(gcpc_pkg::CFG_VCOUNT, 7'd0);
        push_arc(0, 0, 1);
        settle();

        // vertex count lowered in the middle of a graph
        write_reg(gcpc_pkg::CFG_DIRECTED, 7'd0);
        write_reg(gcpc_pkg::CFG_VCOUNT, 7'd8);
        push_arc(6, 7, 0);
        push_arc(0, 1, 0);
        settle();
        write_reg(gcpc_pkg::CFG_VCOUNT, 7'd4);
        push_arc(1, 2, 1);
        settle();

        // vertex count above the maximum acts as the maximum
        write_reg(gcpc_pkg::CFG_DIRECTED, 7'd1);
        write_reg(gcpc_pkg::CFG_VCOUNT, 7'd127);
        write_reg(gcpc_pkg::CFG_BASE, 7'd1);
        push_arc(64, 1, 0);
        push_arc(1, 64, 1);
        settle();

        ph = 0;
        while (total_items < 160)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            dir  = $urandom_range(0, 1);
            base = $urandom_range(0, 1);
            vc   = (ph == 3 || ph == 10) ? 64 : $urandom_range(1, 12);
            write_reg(gcpc_pkg::CFG_DIRECTED, 7'(dir));
            write_reg(gcpc_pkg::CFG_VCOUNT, 7'(vc));
            write_reg(gcpc_pkg::CFG_BASE, 7'(base));
            n = active_n();
            if (ph == 1)
            begin
                hold_req = 1'b1;
                repeat (3) queue_graph(n, base, dir);
            end
            else
                repeat ($urandom_range(1, 3)) queue_graph(n, base, dir);
            settle();
            ph++;
        end
        phases_run = ph;

        if (reach_q.size() != 0)
        begin
            $display("%0t rows still expected: expected 0, actual %0d", $time, reach_q.size());
            errors++;
        end
        $display("covered %0d edges in %0d graphs, %0d rows checked", total_items,
                 graphs_done, rows_seen);
        $display("random phases: %0d, long receiver hold-off done: %0d", phases_run,
                 hold_done);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/gcpc_pkg.sv
sv/gcpc_ram.sv
sv/gcpc_ctrl.sv
sv/gcpc_datapath.sv
sv/graph_closure_and_property_check.sv
test/tb.sv
